### rtl/ped_pkg.sv
// package for the percent escape decoder: escape phase codes,
// character constants and the hex digit and code map helpers
// used by percent_escape_decoder_unit
`default_nettype none

package ped_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned MaxResults = 4;
  localparam int unsigned CountW = $clog2(MaxResults + 1);

  localparam logic [ByteW-1:0] PCT_CHAR = 8'h25;
  localparam logic [ByteW-1:0] NUL_CHAR = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // uppercase hex digit: 0-9 or A-F
  function automatic logic is_hex(input logic [ByteW-1:0] b);
    return ((b >= 8'd48) && (b <= 8'd57)) || ((b >= 8'd65) && (b <= 8'd70));
  endfunction

  function automatic logic [3:0] hex_val(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] v;
    v = 8'd0;
    if ((b >= 8'd48) && (b <= 8'd57)) begin
      v = b - 8'd48;
    end else if ((b >= 8'd65) && (b <= 8'd70)) begin
      v = b - 8'd55;
    end
    return v[3:0];
  endfunction

  // printable codes pass, four high codes fold to punctuation, rest go to zero
  function automatic logic [ByteW-1:0] map_code(input logic [ByteW-1:0] v);
    logic [ByteW-1:0] r;
    if ((v >= 8'h20) && (v <= 8'h7e)) begin
      r = v;
    end else begin
      unique case (v)
        8'h80:   r = 8'h60;
        8'h82:   r = 8'h2c;
        8'h84:   r = 8'h22;
        8'h88:   r = 8'h5e;
        default: r = 8'h00;
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/percent_escape_decoder_unit.sv
// percent escape decoder top level: byte stream in, decoded byte stream out
// depends on ped_pkg for phase codes, constants and the code map
`default_nettype none

// Decodes '%' followed by two uppercase hex digits into one mapped byte and
// copies every other byte; a bad or cut-off escape comes out literally, and
// each string (input transfer with s_tlast set) is closed by a NUL result
// with m_tlast set. Each input byte yields zero to four results, which are
// built combinationally, loaded into a four-entry result buffer and leave it
// one per cycle while m_tready is high. A new byte is taken whenever the
// buffer will be empty after the current cycle, so a stream of ordinary
// bytes runs at one byte per cycle while m_tready is high; a byte that
// yields results holds off the next byte until the single output port sends
// the last of them, and a byte that yields none leaves the input ready.
module percent_escape_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,   // is_last
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast    // out_last
);

  localparam int unsigned W = ped_pkg::ByteW;
  localparam int unsigned N = ped_pkg::MaxResults;
  localparam int unsigned CW = ped_pkg::CountW;

  ped_pkg::phase_t phase, phase_next;
  logic [W-1:0]    held, held_next;

  logic [W-1:0]    buf_byte [N];
  logic [N-1:0]    buf_last;
  logic [CW-1:0]   buf_count;

  logic [W-1:0]    res_byte [N];
  logic [N-1:0]    res_last;
  logic [CW-1:0]   res_count;

  logic            s_xfer, m_xfer;
  logic            b_hex;

  assign s_xfer = s_tvalid && s_tready;
  assign m_xfer = m_tvalid && m_tready;
  assign b_hex  = ped_pkg::is_hex(s_tdata);

  assign s_tready = (buf_count == '0) || ((buf_count == CW'(1)) && m_tready);
  assign m_tvalid = (buf_count != '0);
  assign m_tdata  = buf_byte[0];
  assign m_tlast  = buf_last[0];

  // next escape phase and held digit
  always_comb begin
    phase_next = phase;
    held_next  = held;
    unique case (phase)
      ped_pkg::PH_PCT: begin
        if (b_hex) begin
          phase_next = ped_pkg::PH_DIGIT;
          held_next  = s_tdata;
        end else begin
          phase_next = (s_tdata == ped_pkg::PCT_CHAR) ? ped_pkg::PH_PCT : ped_pkg::PH_IDLE;
        end
      end
      ped_pkg::PH_DIGIT: begin
        if (b_hex) begin
          phase_next = ped_pkg::PH_IDLE;
        end else begin
          phase_next = (s_tdata == ped_pkg::PCT_CHAR) ? ped_pkg::PH_PCT : ped_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = (s_tdata == ped_pkg::PCT_CHAR) ? ped_pkg::PH_PCT : ped_pkg::PH_IDLE;
      end
    endcase
    if (s_tlast) begin
      phase_next = ped_pkg::PH_IDLE;
      held_next  = '0;
    end
  end

  // results of the current input byte, packed from entry 0 up
  always_comb begin
    ped_pkg::phase_t mid;
    for (int i = 0; i < N; i++) begin
      res_byte[i] = '0;
    end
    res_last  = '0;
    res_count = '0;
    mid       = ped_pkg::PH_IDLE;
    unique case (phase)
      ped_pkg::PH_PCT: begin
        if (b_hex) begin
          mid = ped_pkg::PH_DIGIT;
        end else begin
          res_byte[res_count[1:0]] = ped_pkg::PCT_CHAR;
          res_count = res_count + CW'(1);
          if (s_tdata == ped_pkg::PCT_CHAR) begin
            mid = ped_pkg::PH_PCT;
          end else begin
            res_byte[res_count[1:0]] = s_tdata;
            res_count = res_count + CW'(1);
          end
        end
      end
      ped_pkg::PH_DIGIT: begin
        if (b_hex) begin
          res_byte[res_count[1:0]] =
            ped_pkg::map_code({ped_pkg::hex_val(held), ped_pkg::hex_val(s_tdata)});
          res_count = res_count + CW'(1);
        end else begin
          res_byte[res_count[1:0]] = ped_pkg::PCT_CHAR;
          res_count = res_count + CW'(1);
          res_byte[res_count[1:0]] = held;
          res_count = res_count + CW'(1);
          if (s_tdata == ped_pkg::PCT_CHAR) begin
            mid = ped_pkg::PH_PCT;
          end else begin
            res_byte[res_count[1:0]] = s_tdata;
            res_count = res_count + CW'(1);
          end
        end
      end
      default: begin
        if (s_tdata == ped_pkg::PCT_CHAR) begin
          mid = ped_pkg::PH_PCT;
        end else begin
          res_byte[res_count[1:0]] = s_tdata;
          res_count = res_count + CW'(1);
        end
      end
    endcase
    if (s_tlast) begin
      // flush a pending escape literally, then close the string
      if (mid == ped_pkg::PH_PCT) begin
        res_byte[res_count[1:0]] = ped_pkg::PCT_CHAR;
        res_count = res_count + CW'(1);
      end else if (mid == ped_pkg::PH_DIGIT) begin
        res_byte[res_count[1:0]] = ped_pkg::PCT_CHAR;
        res_count = res_count + CW'(1);
        res_byte[res_count[1:0]] = (phase == ped_pkg::PH_PCT) ? s_tdata : held;
        res_count = res_count + CW'(1);
      end
      res_byte[res_count[1:0]] = ped_pkg::NUL_CHAR;
      res_last[res_count[1:0]] = 1'b1;
      res_count = res_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= ped_pkg::PH_IDLE;
      held      <= '0;
      buf_count <= '0;
      buf_last  <= '0;
    end else begin
      if (s_xfer) begin
        phase     <= phase_next;
        held      <= held_next;
        buf_count <= res_count;
        buf_last  <= res_last;
      end else if (m_xfer) begin
        buf_count <= buf_count - CW'(1);
        buf_last  <= {1'b0, buf_last[N-1:1]};
      end
    end
  end

  // result payload: loaded on an input transfer, shifted down on each output transfer
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      for (int i = 0; i < N; i++) begin
        buf_byte[i] <= res_byte[i];
      end
    end else if (m_xfer) begin
      for (int i = 0; i < N - 1; i++) begin
        buf_byte[i] <= buf_byte[i+1];
      end
      buf_byte[N-1] <= '0;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    buf_count <= CW'(N))
    else $error("result buffer count out of range");

  a_term_is_final: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (buf_count == CW'(1)))
    else $error("terminator is not the final buffered result");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && s_tlast) |=> (phase == ped_pkg::PH_IDLE) && (held == '0))
    else $error("escape state not cleared after end of string");

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    s_xfer |-> ((buf_count == '0) || m_xfer))
    else $error("input taken while results still pending");

endmodule

`default_nettype wire
